/* rtl/cmfd_pkg.sv */
`default_nettype none
package cmfd_pkg;

  // Field widths
  localparam int SAMPLE_BITS  = 12;
  localparam int CHANNEL_BITS = 5;
  localparam int MASK_BITS    = 32;
  localparam int THRESH_BITS  = 13;
  localparam int Q_FRAC_BITS  = 12;

  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE   = '1;
  localparam logic [THRESH_BITS-1:0] THRESH_RESET = 13'd2048;

  // Configuration port
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;
  localparam logic REG_FOLD_THRESHOLD = 1'b0;   // register index, paddr[2]

  // Input commands
  localparam logic [1:0] CMD_SCAN       = 2'd0;
  localparam logic [1:0] CMD_CAL_START  = 2'd1;
  localparam logic [1:0] CMD_CAL_SAMPLE = 2'd2;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = 1;
  localparam int QCNT_BITS   = 2;

  // Classified operation
  typedef enum logic [3:0] {
    OP_NOP        = 4'b0001,
    OP_SCAN       = 4'b0010,
    OP_CAL_START  = 4'b0100,
    OP_CAL_SAMPLE = 4'b1000
  } op_t;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [CHANNEL_BITS-1:0] channel;
    logic [SAMPLE_BITS-1:0]  sample;
  } item_t;

  typedef struct packed {
    logic                 folded;
    logic [MASK_BITS-1:0] fold_mask;
    logic                 scan_done;
  } result_t;

  typedef struct packed {
    op_t                     op;
    logic [CHANNEL_BITS-1:0] channel;
    logic [SAMPLE_BITS-1:0]  sample;
    logic                    last;
  } entry_t;

endpackage
`default_nettype wire

/* rtl/calibrated_multichannel_fold_detector_core.sv */
`default_nettype none
// A result passes through the queue, the range stage and the multiply/compare stage
// into the output register.
// Throughput: one item per cycle while result_stall does not hold the pipeline and the queue has room.
// Reset (rst, synchronous): ranges go to min 0 / max full scale, fold mask clears,
// threshold returns to 2048, queue and pipeline empty.
module calibrated_multichannel_fold_detector_core
  import cmfd_pkg::*;
#(
  parameter int NUM_CHANNELS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire item_t                item,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output result_t                   result,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0]      prdata,
  output logic                      pready
);

  logic [THRESH_BITS-1:0] threshold;
  logic                   push;
  entry_t                 push_entry;
  logic                   queue_full;
  logic                   pop;
  logic                   head_valid;
  entry_t                 head;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FOLD_THRESHOLD) ? DATA_BITS'(threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_FOLD_THRESHOLD)) begin
      threshold <= pwdata[THRESH_BITS-1:0];
    end
  end

  cmfd_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  cmfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  cmfd_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .threshold    (threshold),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
`default_nettype wire

/* rtl/cmfd_front.sv */
`default_nettype none
module cmfd_front
  import cmfd_pkg::*;
#(
  parameter int NUM_CHANNELS = 32
) (
  input  wire logic   item_valid,
  output logic        item_stall,
  input  wire item_t  item,
  input  wire logic   queue_full,
  output logic        push,
  output entry_t      push_entry
);

  logic in_range;

  // Transfer whenever the queue has room
  assign item_stall = queue_full;
  assign push       = item_valid && !queue_full;

  assign in_range = {1'b0, item.channel} < (CHANNEL_BITS+1)'(NUM_CHANNELS);

  // Classify the command
  always_comb begin
    push_entry.channel = item.channel;
    push_entry.sample  = item.sample;
    push_entry.last    = item.channel == CHANNEL_BITS'(NUM_CHANNELS - 1);
    case (item.cmd)
      CMD_SCAN:       push_entry.op = in_range ? OP_SCAN : OP_NOP;
      CMD_CAL_START:  push_entry.op = OP_CAL_START;
      CMD_CAL_SAMPLE: push_entry.op = in_range ? OP_CAL_SAMPLE : OP_NOP;
      default:        push_entry.op = OP_NOP;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/cmfd_queue.sv */
`default_nettype none
module cmfd_queue
  import cmfd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  output logic        full,
  input  wire logic   pop,
  output logic        head_valid,
  output entry_t      head
);

  entry_t                slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr;
  logic [QPTR_BITS-1:0]  rd_ptr;
  logic [QCNT_BITS-1:0]  count;

  assign full       = count == QCNT_BITS'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

/* rtl/cmfd_back.sv */
`default_nettype none
module cmfd_back
  import cmfd_pkg::*;
#(
  parameter int NUM_CHANNELS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   head_valid,
  input  wire entry_t                 head,
  output logic                        pop,
  input  wire logic [THRESH_BITS-1:0] threshold,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output result_t                     result
);

  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PROD_W   = SAMPLE_BITS + THRESH_BITS;

  logic [SAMPLE_BITS-1:0]  range_min [NUM_CHANNELS];
  logic [SAMPLE_BITS-1:0]  range_max [NUM_CHANNELS];
  logic [MASK_BITS-1:0]    fold_bits;

  logic [CH_IDX_W-1:0]     ch_idx;
  logic [SAMPLE_BITS-1:0]  lo;
  logic [SAMPLE_BITS-1:0]  hi;
  logic [SAMPLE_BITS-1:0]  dist_raw;
  logic [SAMPLE_BITS-1:0]  span_raw;

  logic                    p1_valid;
  op_t                     p1_op;
  logic [CHANNEL_BITS-1:0] p1_channel;
  logic                    p1_last;
  logic [SAMPLE_BITS-1:0]  p1_dist;
  logic [SAMPLE_BITS-1:0]  p1_span;

  logic                    out_free;
  logic                    p1_ready;
  logic [PROD_W-1:0]       lhs;
  logic [PROD_W-1:0]       rhs;
  logic                    hit;
  logic [MASK_BITS-1:0]    fold_bits_next;

  // Pipeline flow
  assign out_free = !result_valid || !result_stall;
  assign p1_ready = !p1_valid || out_free;
  assign pop      = head_valid && p1_ready;

  // Stage 1: range lookup, clamped distance and span
  assign ch_idx   = head.channel[CH_IDX_W-1:0];
  assign lo       = range_min[ch_idx];
  assign hi       = range_max[ch_idx];
  assign span_raw = (hi > lo) ? hi - lo : '0;

  always_comb begin
    dist_raw = (head.sample > lo) ? head.sample - lo : '0;
    if (dist_raw > span_raw) begin
      dist_raw = span_raw;
    end
  end

  // Calibration range update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        range_min[i] <= '0;
        range_max[i] <= FULL_SCALE;
      end
    end else if (pop) begin
      case (head.op)
        OP_CAL_START: begin
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            range_min[i] <= FULL_SCALE;
            range_max[i] <= '0;
          end
        end
        OP_CAL_SAMPLE: begin
          if (head.sample < lo) begin
            range_min[ch_idx] <= head.sample;
          end
          if (head.sample > hi) begin
            range_max[ch_idx] <= head.sample;
          end
        end
        default: ;
      endcase
    end
  end

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (p1_ready) begin
      p1_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      p1_op      <= head.op;
      p1_channel <= head.channel;
      p1_last    <= head.last;
      p1_dist    <= dist_raw;
      p1_span    <= span_raw;
    end
  end

  // Stage 2: dist * 4096 > threshold * span
  assign lhs = PROD_W'({p1_dist, {Q_FRAC_BITS{1'b0}}});
  assign rhs = PROD_W'(p1_span) * PROD_W'(threshold);
  assign hit = (p1_op == OP_SCAN) && (p1_span != '0) && (lhs > rhs);

  always_comb begin
    fold_bits_next = fold_bits;
    if (p1_op == OP_SCAN) begin
      fold_bits_next[p1_channel] = hit;
    end
  end

  // Fold mask and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      fold_bits    <= '0;
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= p1_valid;
      if (p1_valid) begin
        fold_bits <= fold_bits_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && p1_valid) begin
      result.folded    <= hit;
      result.fold_mask <= fold_bits_next;
      result.scan_done <= (p1_op == OP_SCAN) && p1_last;
    end
  end

  a_mask_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(fold_bits))
    else $error("fold mask changed while result stalled");

  a_fold_only_scan: assert property (@(posedge clk) disable iff (rst)
    p1_valid && (p1_op != OP_SCAN) |-> !hit)
    else $error("fold flagged on non-scan item");

  a_cal_start: assert property (@(posedge clk) disable iff (rst)
    pop && (head.op == OP_CAL_START) |=> (range_min[0] == FULL_SCALE) && (range_max[0] == '0))
    else $error("calibration start did not reset ranges");

endmodule
`default_nettype wire

/* tb/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cmfd_pkg::*;

  localparam int NUM_CH          = 32;
  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 67;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int N_DIRECTED      = 24;

  // Command code the block must ignore
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [ADDR_BITS-1:0] THRESH_ADDR = {REG_FOLD_THRESHOLD, 2'b00};

  // Threshold per phase; -1 picks a random value
  localparam int THRESH_PLAN [PHASES] = '{0, 4096, -1, 8191, 4095, -1, 1, -1, 2048};

  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t want;
  } fold_case_t;

  // Directed cases; want is used only where typed is set
  localparam fold_case_t DIRECTED [N_DIRECTED] = '{
    '{'{CMD_SCAN,       5'd0,  12'd0},    1'b1, '{1'b0, 32'h0000_0000, 1'b0}},
    '{'{CMD_SCAN,       5'd31, 12'd4095}, 1'b1, '{1'b1, 32'h8000_0000, 1'b1}},
    '{'{CMD_SCAN,       5'd5,  12'd2048}, 1'b0, '0},
    '{'{CMD_SCAN,       5'd5,  12'd2047}, 1'b0, '0},
    '{'{CMD_UNUSED,     5'd31, 12'd4095}, 1'b1, '{1'b0, 32'h8000_0000, 1'b0}},
    '{'{CMD_SCAN,       5'd0,  12'd4095}, 1'b0, '0},
    '{'{CMD_CAL_START,  5'd17, 12'h5A5},  1'b1, '{1'b0, 32'h8000_0001, 1'b0}},
    '{'{CMD_SCAN,       5'd31, 12'd4095}, 1'b1, '{1'b0, 32'h0000_0001, 1'b1}},
    '{'{CMD_SCAN,       5'd0,  12'd0},    1'b1, '{1'b0, 32'h0000_0000, 1'b0}},
    '{'{CMD_CAL_SAMPLE, 5'd3,  12'd4095}, 1'b1, '{1'b0, 32'h0000_0000, 1'b0}},
    '{'{CMD_SCAN,       5'd3,  12'd4095}, 1'b1, '{1'b0, 32'h0000_0000, 1'b0}},
    '{'{CMD_CAL_SAMPLE, 5'd3,  12'd0},    1'b1, '{1'b0, 32'h0000_0000, 1'b0}},
    '{'{CMD_SCAN,       5'd3,  12'd4095}, 1'b0, '0},
    '{'{CMD_SCAN,       5'd3,  12'd0},    1'b0, '0},
    '{'{CMD_CAL_SAMPLE, 5'd10, 12'd1000}, 1'b0, '0},
    '{'{CMD_CAL_SAMPLE, 5'd10, 12'd3000}, 1'b0, '0},
    '{'{CMD_SCAN,       5'd10, 12'd500},  1'b0, '0},
    '{'{CMD_SCAN,       5'd10, 12'd3500}, 1'b0, '0},
    '{'{CMD_SCAN,       5'd10, 12'd2000}, 1'b0, '0},
    '{'{CMD_SCAN,       5'd10, 12'd2001}, 1'b0, '0},
    '{'{CMD_CAL_SAMPLE, 5'd31, 12'd2048}, 1'b0, '0},
    '{'{CMD_CAL_SAMPLE, 5'd31, 12'd2049}, 1'b0, '0},
    '{'{CMD_SCAN,       5'd31, 12'd2049}, 1'b0, '0},
    '{'{CMD_SCAN,       5'd31, 12'd2048}, 1'b0, '0}
  };

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 item_valid   = 1'b0;
  logic                 item_stall;
  item_t                item         = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;
  logic                 psel         = 1'b0;
  logic                 penable      = 1'b0;
  logic                 pwrite       = 1'b0;
  logic [ADDR_BITS-1:0] paddr        = '0;
  logic [DATA_BITS-1:0] pwdata       = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  calibrated_multichannel_fold_detector_core uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Shadow of the block's calibration ranges, mask and threshold
  logic [SAMPLE_BITS-1:0] cal_lo [NUM_CH];
  logic [SAMPLE_BITS-1:0] cal_hi [NUM_CH];
  logic [MASK_BITS-1:0]   mask_model;
  logic [THRESH_BITS-1:0] thresh_model;

  result_t pending_folds [$];
  result_t fold_want;
  int      errors        = 0;
  int      results_seen  = 0;
  int      cycle_count   = 0;
  int      send_idle_pct = 34;
  int      recv_idle_pct = 81;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Fold decision and shadow-state update for one transfer
  function automatic result_t predict_fold(input item_t it);
    result_t                            r;
    logic [SAMPLE_BITS-1:0]             lo, hi, span, delta;
    logic [SAMPLE_BITS+Q_FRAC_BITS-1:0] scaled;
    logic [SAMPLE_BITS+THRESH_BITS-1:0] limit;
    int                                 c;
    r  = '0;
    lo = cal_lo[it.channel];
    hi = cal_hi[it.channel];
    case (it.cmd)
      CMD_CAL_START: begin
        for (c = 0; c < NUM_CH; c++) begin
          cal_lo[c] = FULL_SCALE;
          cal_hi[c] = '0;
        end
      end
      CMD_CAL_SAMPLE: begin
        if (it.sample < lo) cal_lo[it.channel] = it.sample;
        if (it.sample > hi) cal_hi[it.channel] = it.sample;
      end
      CMD_SCAN: begin
        span  = (hi > lo) ? hi - lo : '0;
        delta = (it.sample > lo) ? it.sample - lo : '0;
        if (delta > span) delta = span;
        scaled = {delta, {Q_FRAC_BITS{1'b0}}};
        limit  = thresh_model * span;
        r.folded = (span != 0) && (scaled > limit);
        mask_model[it.channel] = r.folded;
        r.scan_done = (it.channel == NUM_CH - 1);
      end
      default: ;
    endcase
    r.fold_mask = mask_model;
    return r;
  endfunction

  // Extremes get extra weight
  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(7))
      0:       return '0;
      1:       return FULL_SCALE;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic send_item(input item_t it, input logic typed, input result_t want);
    result_t fold_exp;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    fold_exp = predict_fold(it);
    pending_folds.push_back(typed ? want : fold_exp);
  endtask

  task automatic reg_write(input logic [ADDR_BITS-1:0] addr,
                           input logic [DATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_read(input logic [ADDR_BITS-1:0] addr,
                          output logic [DATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver backpressure
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_folds.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
      end else begin
        fold_want = pending_folds.pop_front();
        if (result.folded !== fold_want.folded)
          report_mismatch($sformatf("result %0d folded %b, want %b",
                                    results_seen, result.folded, fold_want.folded));
        if (result.fold_mask !== fold_want.fold_mask)
          report_mismatch($sformatf("result %0d fold_mask %h, want %h",
                                    results_seen, result.fold_mask, fold_want.fold_mask));
        if (result.scan_done !== fold_want.scan_done)
          report_mismatch($sformatf("result %0d scan_done %b, want %b",
                                    results_seen, result.scan_done, fold_want.scan_done));
      end
      results_seen++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("calibrated_multichannel_fold_detector_core: mismatch");
      $finish;
    end
  end

  initial begin
    item_t                  burst [$];
    logic [THRESH_BITS-1:0] thr;
    logic [DATA_BITS-1:0]   rd;
    int                     p, c, lo_ch, hi_ch, n;

    for (c = 0; c < NUM_CH; c++) begin
      cal_lo[c] = '0;
      cal_hi[c] = FULL_SCALE;
    end
    mask_model   = '0;
    thresh_model = THRESH_RESET;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Threshold comes out of reset at one half
    reg_read(THRESH_ADDR, rd);
    if (rd[THRESH_BITS-1:0] !== THRESH_RESET)
      report_mismatch($sformatf("threshold after reset %0d", rd[THRESH_BITS-1:0]));

    foreach (DIRECTED[i]) send_item(DIRECTED[i].it, DIRECTED[i].typed, DIRECTED[i].want);
    item_valid <= 1'b0;

    for (p = 0; p < PHASES; p++) begin
      send_idle_pct = (p < 3) ? 34 : (p < 6) ? 81 : 0;
      recv_idle_pct = (p < 3) ? 81 : (p < 6) ? 34 : 0;

      // Reprogram only once the pipeline has drained
      while (pending_folds.size() != 0) @(posedge clk);
      thr = (THRESH_PLAN[p] < 0) ? THRESH_BITS'($urandom_range(4096))
                                 : THRESH_BITS'(THRESH_PLAN[p]);
      reg_write(THRESH_ADDR, {(DATA_BITS-THRESH_BITS)'($urandom), thr});
      thresh_model = thr;
      reg_read(THRESH_ADDR, rd);
      if (rd[THRESH_BITS-1:0] !== thr)
        report_mismatch($sformatf("threshold readback %0d, wrote %0d",
                                  rd[THRESH_BITS-1:0], thr));

      // Mostly calibrate-then-scan sequences, with some noise mixed in
      burst.delete();
      while (burst.size() < ITEMS_PER_PHASE) begin
        lo_ch = $urandom_range(NUM_CH - 1);
        case ($urandom_range(9))
          0: begin
            burst.push_back(item_t'{CMD_CAL_START, CHANNEL_BITS'($urandom), rand_sample()});
            hi_ch = lo_ch + $urandom_range(11);
            if (hi_ch >= NUM_CH) hi_ch = NUM_CH - 1;
            for (c = lo_ch; c <= hi_ch; c++) begin
              n = $urandom_range(1, 3);
              repeat (n) burst.push_back(item_t'{CMD_CAL_SAMPLE, CHANNEL_BITS'(c),
                                                 rand_sample()});
            end
          end
          1, 2, 3, 4, 5: begin
            // scan sweep, often running up to the last channel
            hi_ch = lo_ch + $urandom_range(NUM_CH - 1);
            if (hi_ch >= NUM_CH) hi_ch = NUM_CH - 1;
            for (c = lo_ch; c <= hi_ch; c++)
              burst.push_back(item_t'{CMD_SCAN, CHANNEL_BITS'(c), rand_sample()});
          end
          6, 7: begin
            n = $urandom_range(2, 6);
            repeat (n) burst.push_back(item_t'{CMD_CAL_SAMPLE, CHANNEL_BITS'($urandom),
                                               rand_sample()});
          end
          default: begin
            n = $urandom_range(1, 4);
            repeat (n) burst.push_back(item_t'{2'($urandom), CHANNEL_BITS'($urandom),
                                               SAMPLE_BITS'($urandom)});
          end
        endcase
      end

      foreach (burst[i]) send_item(burst[i], 1'b0, '0);
      item_valid <= 1'b0;
    end

    while (pending_folds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("calibrated_multichannel_fold_detector_core: match");
    else
      $display("calibrated_multichannel_fold_detector_core: mismatch");
    $finish;
  end

endmodule
